[rtl/core/sqlts_pkg.sv]
// ----------------------------------------------------------------------------
// sqlts_pkg
// Shared types and character codes for the SQL token splitter.
// ----------------------------------------------------------------------------
package sqlts_pkg;

    // Lexer modes
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_HELD   = 3'd1,
        MODE_LIT    = 3'd2,
        MODE_LITQ   = 3'd3,
        MODE_BLOB   = 3'd4
    } lex_mode_t;

    typedef struct packed {
        lex_mode_t   mode;
        logic [7:0]  held;
        logic        word_open;
        logic        word_sx;    // open word is exactly x or X
        logic        last_sx;    // last finished token is exactly x or X
    } lex_state_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        token_start;
        logic        statement_end;
        logic        run_last;
    } tok_t;

    // Lexer step: next state plus up to two result tokens
    typedef struct packed {
        lex_state_t  st;
        tok_t        r0;
        tok_t        r1;
        logic [1:0]  cnt;
    } ctx_t;

    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Result queue depth
    localparam int RESQ_DEPTH = 4;

endpackage

[rtl/core/sqlts_lex.sv]
// ----------------------------------------------------------------------------
// sqlts_lex
// One-byte lexer step: from the current state and one input byte, builds the
// next state and up to two result tokens.
// ----------------------------------------------------------------------------
module sqlts_lex (
    input  sqlts_pkg::lex_state_t state,
    input  logic [7:0]            in_byte,
    input  logic                  text_last,
    output sqlts_pkg::ctx_t       result
);
    import sqlts_pkg::*;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_COMMA) || (c == CH_SEMI) ||
               (c == CH_STAR) || (c == CH_EQ) || (c == CH_PLUS) || (c == CH_MINUS) ||
               (c == CH_SLASH);
    endfunction

    function automatic ctx_t put(input ctx_t x_in, input logic [7:0] b,
                                 input logic valid, input logic start);
        ctx_t x;
        tok_t t;
        x = x_in;
        t.out_byte      = b;
        t.byte_valid    = valid;
        t.token_start   = start;
        t.statement_end = 1'b0;
        t.run_last      = 1'b0;
        if (x.cnt == 2'd0)
        begin
            x.r0  = t;
            x.cnt = 2'd1;
        end
        else if (x.cnt == 2'd1)
        begin
            x.r1  = t;
            x.cnt = 2'd2;
        end
        return x;
    endfunction

    function automatic ctx_t close_word(input ctx_t x_in);
        ctx_t x;
        x = x_in;
        if (x.st.word_open)
        begin
            x.st.last_sx   = x.st.word_sx;
            x.st.word_open = 1'b0;
            x.st.word_sx   = 1'b0;
        end
        return x;
    endfunction

    function automatic ctx_t emit_word(input ctx_t x_in, input logic [7:0] c);
        ctx_t x;
        x = x_in;
        if (!x.st.word_open)
        begin
            x = put(x, c, 1'b1, 1'b1);
            x.st.word_open = 1'b1;
            x.st.word_sx   = (c == CH_X_LO) || (c == CH_X_UP);
        end
        else
        begin
            x = put(x, c, 1'b1, 1'b0);
            x.st.word_sx = 1'b0;
        end
        return x;
    endfunction

    function automatic ctx_t emit_token(input ctx_t x_in, input logic [7:0] c);
        ctx_t x;
        x = close_word(x_in);
        x = put(x, c, 1'b1, 1'b1);
        x.st.last_sx = 1'b0;
        return x;
    endfunction

    function automatic ctx_t proc_normal(input ctx_t x_in, input logic [7:0] c);
        ctx_t x;
        logic sx;
        x  = x_in;
        sx = 1'b0;
        if (is_space(c))
        begin
            x = close_word(x);
        end
        else if (c == CH_QUOTE)
        begin
            sx = x.st.word_open ? x.st.word_sx : x.st.last_sx;
            x  = close_word(x);
            x.st.last_sx = 1'b0;
            if (sx)
            begin
                // x'...' continues the x token as a hex blob
                x = put(x, c, 1'b1, 1'b0);
                x.st.mode = MODE_BLOB;
            end
            else
            begin
                x = put(x, c, 1'b1, 1'b1);
                x.st.mode = MODE_LIT;
            end
        end
        else if (is_punct(c))
        begin
            x = emit_token(x, c);
        end
        else if (c == CH_LT || c == CH_GT)
        begin
            x = close_word(x);
            x.st.mode = MODE_HELD;
            x.st.held = c;
        end
        else if (c == CH_DOT)
        begin
            if (x.st.word_open)
            begin
                x.st.mode = MODE_HELD;
                x.st.held = c;
            end
            else
            begin
                x = emit_token(x, c);
            end
        end
        else if (c == CH_BANG)
        begin
            x.st.mode = MODE_HELD;
            x.st.held = c;
        end
        else
        begin
            x = emit_word(x, c);
        end
        return x;
    endfunction

    function automatic ctx_t proc_held(input ctx_t x_in, input logic [7:0] c);
        ctx_t x;
        logic [7:0] h;
        x = x_in;
        h = x.st.held;
        x.st.mode = MODE_NORMAL;
        x.st.held = 8'h00;
        if (h == CH_DOT)
        begin
            // dot stays in the word only when a digit follows
            if (c >= CH_ZERO && c <= CH_NINE)
                x = emit_word(x, h);
            else
                x = emit_token(x, h);
            x = proc_normal(x, c);
        end
        else if (h == CH_LT || h == CH_GT)
        begin
            x = emit_token(x, h);
            if (c == CH_EQ || (h == CH_LT && c == CH_GT))
                x = put(x, c, 1'b1, 1'b0);
            else
                x = proc_normal(x, c);
        end
        else
        begin
            // held bang: != is an operator, otherwise the bang is a word byte
            if (c == CH_EQ)
            begin
                x = emit_token(x, h);
                x = put(x, c, 1'b1, 1'b0);
            end
            else
            begin
                x = emit_word(x, h);
                x = proc_normal(x, c);
            end
        end
        return x;
    endfunction

    always_comb
    begin
        result.st  = state;
        result.r0  = '0;
        result.r1  = '0;
        result.cnt = 2'd0;

        unique case (state.mode)
            MODE_HELD:
            begin
                result = proc_held(result, in_byte);
            end
            MODE_LIT:
            begin
                result = put(result, in_byte, 1'b1, 1'b0);
                if (in_byte == CH_QUOTE)
                    result.st.mode = MODE_LITQ;
            end
            MODE_LITQ:
            begin
                // a second quote folds into the first one
                if (in_byte == CH_QUOTE)
                    result.st.mode = MODE_LIT;
                else
                begin
                    result.st.mode = MODE_NORMAL;
                    result = proc_normal(result, in_byte);
                end
            end
            MODE_BLOB:
            begin
                result = put(result, in_byte, 1'b1, 1'b0);
                if (in_byte == CH_QUOTE)
                    result.st.mode = MODE_NORMAL;
            end
            default:
            begin
                result.st.mode = MODE_NORMAL;
                result = proc_normal(result, in_byte);
            end
        endcase

        if (text_last)
        begin
            // flush the held byte, then return to the reset state
            if (result.st.mode == MODE_HELD)
            begin
                if (result.st.held == CH_BANG)
                    result = emit_word(result, result.st.held);
                else
                    result = emit_token(result, result.st.held);
            end
            result.st = '0;
            if (result.cnt == 2'd0)
                result = put(result, 8'h00, 1'b0, 1'b0);
            if (result.cnt == 2'd2)
                result.r1.statement_end = 1'b1;
            else
                result.r0.statement_end = 1'b1;
        end

        if (result.cnt == 2'd2)
            result.r1.run_last = 1'b1;
        else if (result.cnt == 2'd1)
            result.r0.run_last = 1'b1;
    end

endmodule

[rtl/core/sql_token_splitter_core.sv]
// ----------------------------------------------------------------------------
// sql_token_splitter_core
// Streaming SQL tokenizer: SQL text in one byte per transaction, token bytes
// out tagged with token start, statement end and end of the byte's results.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one text byte per transaction; s_tlast marks the final
//   byte of a statement and flushes any held byte. Master side delivers
//   result tokens in order; m_tlast marks the last result caused by one
//   input byte. Whitespace and folded quotes produce no result unless the
//   byte is final; a held operator byte and the byte after it may produce two.
//   A result enters the queue at its input transaction and is presented
//   once the results ahead of it have drained. Throughput: one input byte
//   per cycle while s_tready is high, bounded by the single output port of
//   the four-entry result queue; bytes that cause two results drain at one
//   result per cycle, so a steady run of them is held to the output rate.
//   s_tready is high whenever the queue has room for two results, so input
//   is taken while earlier results still wait at the output.
//   When the receiver stalls, the queue fills and s_tready drops; nothing
//   is lost. Reset empties the queue and returns the lexer to normal mode
//   with no word open and nothing held.
// ----------------------------------------------------------------------------
module sql_token_splitter_core #(
    parameter int RESQ_DEPTH = sqlts_pkg::RESQ_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // text_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [2:0]  m_tuser,   // [0] byte_valid, [1] token_start, [2] statement_end
    output logic        m_tlast    // run_last
);
    import sqlts_pkg::*;

    localparam int PTR_W = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(RESQ_DEPTH + 1);

    lex_state_t          state_reg;
    lex_state_t          state_next;
    ctx_t                lex_out;
    tok_t                q_mem_reg [RESQ_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [PTR_W-1:0]    wr_ptr_p1;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                in_fire;
    logic                out_fire;
    logic [1:0]          push_cnt;
    tok_t                head;

    sqlts_lex u_lex (
        .state     (state_reg),
        .in_byte   (s_tdata),
        .text_last (s_tlast),
        .result    (lex_out)
    );

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RESQ_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign s_tready = (cnt_reg <= CNT_W'(RESQ_DEPTH - 2));
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign push_cnt = in_fire ? lex_out.cnt : 2'd0;
    assign wr_ptr_p1 = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        state_next  = in_fire ? lex_out.st : state_reg;
        rd_ptr_next = out_fire ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case (push_cnt)
            2'd1:    wr_ptr_next = wr_ptr_p1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_p1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        cnt_next = cnt_reg + CNT_W'(push_cnt) - CNT_W'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Result queue payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            q_mem_reg[wr_ptr_reg] <= lex_out.r0;
        if (push_cnt == 2'd2)
            q_mem_reg[wr_ptr_p1] <= lex_out.r1;
    end

    assign head     = q_mem_reg[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = head.out_byte;
    assign m_tuser  = {head.statement_end, head.token_start, head.byte_valid};
    assign m_tlast  = head.run_last;

    // Queue never overfills
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(RESQ_DEPTH))
        else $error("result queue count above depth");

    // Final byte of a statement returns the lexer to its reset state
    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tlast) |=> (state_reg == '0))
        else $error("lexer state not cleared after statement end");

    // Final byte of a statement always queues at least one result
    a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tlast) |-> (lex_out.cnt != 2'd0))
        else $error("statement end produced no result");

    // Queue count holds steady when nothing is pushed or popped
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_fire && !out_fire) |=> $stable(cnt_reg))
        else $error("queue count changed without a transaction");

endmodule
